// ===== design/ttyld_pkg.sv =====
// ----------------------------------------------------------------------------
// ttyld_pkg
// Shared types, codes and constants for the terminal line discipline.
// ----------------------------------------------------------------------------
package ttyld_pkg;

  // default buffer depth for line and receive ring
  localparam int BUF_SIZE_DEF = 16;

  // operation codes carried in tuser
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  // result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register indexes
  localparam logic [2:0] REG_ECHO  = 3'd0;
  localparam logic [2:0] REG_CANON = 3'd1;
  localparam logic [2:0] REG_CRNL  = 3'd2;
  localparam logic [2:0] REG_ERASE = 3'd3;
  localparam logic [2:0] REG_KILL  = 3'd4;
  localparam logic [2:0] REG_EOF   = 3'd5;

  // character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // configuration registers
  typedef struct packed {
    logic       echo_enable;
    logic       canonical_mode;
    logic       cr_to_nl;
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] eof_char;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture op and character
    logic flush;      // clear line and ring
    logic read_pop;   // produce read reply and pop a byte
    logic push_ch;    // push the current character into the ring
    logic push_line;  // push the next line byte into the ring
    logic idx_clr;    // restart the line walk
    logic len_dec;    // drop one line character
    logic len_clr;    // empty the line
    logic append;     // append the current character to the line
    logic set_ready;  // mark line ready
    logic echo_start; // start an echo sequence
    logic echo_bs;    // echo byte is backspace rather than the character
    logic echo_emit;  // send the current echo piece
    logic last;       // final result of this item
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       is_erase;
    logic       is_kill;
    logic       is_eof;
    logic       is_nl;
    logic       len_zero;
    logic       can_append;
    logic       idx_done;
    logic       piece_final;
    logic       slot_free;
  } sts_t;

endpackage

// ===== design/ttyld_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttyld_ctrl
// Sequencer for one item: decode, echo pieces, kill repeats and line walk.
// ----------------------------------------------------------------------------
module ttyld_ctrl import ttyld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_ECHO = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       kill_q, kill_d;
  logic       nl_q, nl_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kill_q  <= 1'b0;
      nl_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      kill_q  <= kill_d;
      nl_q    <= nl_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    kill_d  = kill_q;
    nl_d    = nl_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          OP_READ: begin
            if (sts_i.slot_free) begin
              cmd_o.read_pop = 1'b1;
              cmd_o.last     = 1'b1;
              state_d        = S_IDLE;
            end
          end
          OP_FLUSH: begin
            cmd_o.flush = 1'b1;
            state_d     = S_IDLE;
          end
          OP_CHAR: begin
            state_d = S_IDLE;
            kill_d  = 1'b0;
            nl_d    = 1'b0;
            if (!cfg_i.canonical_mode) begin
              cmd_o.push_ch = 1'b1;
              if (cfg_i.echo_enable) begin
                cmd_o.echo_start = 1'b1;
                state_d          = S_ECHO;
              end
            end else if (sts_i.is_erase) begin
              if (!sts_i.len_zero) begin
                cmd_o.len_dec = 1'b1;
                if (cfg_i.echo_enable) begin
                  cmd_o.echo_start = 1'b1;
                  cmd_o.echo_bs    = 1'b1;
                  state_d          = S_ECHO;
                end
              end
            end else if (sts_i.is_kill) begin
              if (!sts_i.len_zero) begin
                if (!cfg_i.echo_enable) begin
                  cmd_o.len_clr = 1'b1;
                end else begin
                  cmd_o.len_dec    = 1'b1;
                  cmd_o.echo_start = 1'b1;
                  cmd_o.echo_bs    = 1'b1;
                  kill_d           = 1'b1;
                  state_d          = S_ECHO;
                end
              end
            end else if (sts_i.is_eof) begin
              cmd_o.set_ready = 1'b1;
            end else begin
              if (sts_i.can_append) begin
                cmd_o.append = 1'b1;
              end
              if (sts_i.can_append && cfg_i.echo_enable) begin
                cmd_o.echo_start = 1'b1;
                nl_d             = sts_i.is_nl;
                state_d          = S_ECHO;
              end else if (sts_i.is_nl) begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_PUSH;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ECHO: begin
        if (sts_i.slot_free) begin
          cmd_o.echo_emit = 1'b1;
          cmd_o.last      = sts_i.piece_final && !(kill_q && !sts_i.len_zero);
          if (sts_i.piece_final) begin
            if (kill_q && !sts_i.len_zero) begin
              cmd_o.len_dec    = 1'b1;
              cmd_o.echo_start = 1'b1;
              cmd_o.echo_bs    = 1'b1;
            end else if (nl_q) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_PUSH;
            end else begin
              state_d = S_IDLE;
            end
          end
        end
      end
      S_PUSH: begin
        if (sts_i.idx_done) begin
          cmd_o.len_clr   = 1'b1;
          cmd_o.set_ready = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.push_line = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== design/ttyld_dp.sv =====
// ----------------------------------------------------------------------------
// ttyld_dp
// Line buffer, receive ring, echo piece generator and result register.
// ----------------------------------------------------------------------------
module ttyld_dp import ttyld_pkg::*; #(
  parameter int BUF_SIZE = BUF_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  char_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        out_kind_o,
  output logic        out_last_o,
  output logic [15:0] out_data_o
);

  localparam int LEN_W  = $clog2(BUF_SIZE);
  localparam int FILL_W = $clog2(BUF_SIZE + 1);
  localparam logic [LEN_W-1:0]  LEN_MAX = LEN_W'(BUF_SIZE - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUF_SIZE);

  logic [1:0]        op_q;
  logic [7:0]        ch_q;
  logic [7:0]        line_q [BUF_SIZE];
  logic [7:0]        ring_q [BUF_SIZE];
  logic [LEN_W-1:0]  len_q, idx_q, wp_q, rp_q;
  logic [FILL_W-1:0] fill_q;
  logic              ready_q;
  logic [7:0]        echo_q;
  logic [1:0]        piece_q;
  logic              out_valid_q, out_kind_q, out_last_q;
  logic [7:0]        out_byte_q;
  logic              out_dv_q, out_ir_q, out_eol_q;

  logic              push;
  logic              ring_full;
  logic              e_triple, e_caret;
  logic [1:0]        piece_end;
  logic [7:0]        echo_data;
  logic              slot_free;

  // status for the sequencer
  assign slot_free = !out_valid_q || out_ready_i;
  assign sts_o.op          = op_q;
  assign sts_o.is_erase    = (ch_q == cfg_i.erase_char) || (ch_q == CH_BS) || (ch_q == CH_DEL);
  assign sts_o.is_kill     = (ch_q == cfg_i.kill_char);
  assign sts_o.is_eof      = (ch_q == cfg_i.eof_char);
  assign sts_o.is_nl       = (ch_q == CH_NL);
  assign sts_o.len_zero    = (len_q == '0);
  assign sts_o.can_append  = (len_q < LEN_MAX);
  assign sts_o.idx_done    = (idx_q == len_q);
  assign sts_o.piece_final = (piece_q == piece_end);
  assign sts_o.slot_free   = slot_free;

  // echo piece selection
  always_comb begin
    e_triple = (echo_q == cfg_i.erase_char) || (echo_q == CH_BS);
    e_caret  = ((echo_q < CH_SPACE) || echo_q[7]) && (echo_q != CH_NL) &&
               (echo_q != CH_TAB) && (echo_q != CH_CR);
    if (e_triple) begin
      piece_end = 2'd2;
      echo_data = (piece_q == 2'd1) ? CH_SPACE : CH_BS;
    end else if (e_caret) begin
      piece_end = 2'd1;
      echo_data = (piece_q == 2'd0) ? CH_CARET : (echo_q + CH_AT);
    end else begin
      piece_end = 2'd0;
      echo_data = echo_q;
    end
  end

  // ring push source
  assign push      = cmd_i.push_ch || cmd_i.push_line;
  assign ring_full = (fill_q == FILL_MAX);

  // item capture with carriage return translation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      ch_q <= (cfg_i.cr_to_nl && char_i == CH_CR) ? CH_NL : char_i;
    end
    if (cmd_i.echo_start) begin
      echo_q  <= cmd_i.echo_bs ? CH_BS : ch_q;
    end
  end

  // line and ring storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      line_q[len_q] <= ch_q;
    end
    if (push && !ring_full) begin
      ring_q[wp_q] <= cmd_i.push_line ? line_q[idx_q] : ch_q;
    end
  end

  // counters and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      idx_q   <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
      piece_q <= '0;
    end else if (cmd_i.flush) begin
      len_q   <= '0;
      wp_q    <= '0;
      rp_q    <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      if (cmd_i.len_clr) begin
        len_q <= '0;
      end else if (cmd_i.len_dec) begin
        len_q <= len_q - 1'b1;
      end else if (cmd_i.append) begin
        len_q <= len_q + 1'b1;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.push_line) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_ready) begin
        ready_q <= 1'b1;
      end else if (cmd_i.read_pop && cfg_i.canonical_mode) begin
        ready_q <= 1'b0;
      end
      if (push && !ring_full) begin
        wp_q   <= (wp_q == LEN_MAX) ? '0 : wp_q + 1'b1;
        fill_q <= fill_q + 1'b1;
      end else if (cmd_i.read_pop && fill_q != '0) begin
        rp_q   <= (rp_q == LEN_MAX) ? '0 : rp_q + 1'b1;
        fill_q <= fill_q - 1'b1;
      end
      if (cmd_i.echo_start) begin
        piece_q <= '0;
      end else if (cmd_i.echo_emit) begin
        piece_q <= piece_q + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.echo_emit || cmd_i.read_pop) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.echo_emit) begin
      out_kind_q <= KIND_ECHO;
      out_byte_q <= echo_data;
      out_dv_q   <= 1'b0;
      out_ir_q   <= 1'b0;
      out_eol_q  <= 1'b0;
      out_last_q <= cmd_i.last;
    end else if (cmd_i.read_pop) begin
      out_kind_q <= KIND_READ;
      out_byte_q <= (fill_q != '0) ? ring_q[rp_q] : 8'h00;
      out_dv_q   <= (fill_q != '0);
      out_ir_q   <= ready_q || (fill_q != '0);
      out_eol_q  <= (fill_q != '0) && cfg_i.canonical_mode && (ring_q[rp_q] == CH_NL);
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {5'b0, out_eol_q, out_ir_q, out_dv_q, out_byte_q};

endmodule

// ===== design/tty_line_discipline_top.sv =====
// An item is taken in S_IDLE and decoded in the next state, S_EXEC; each echo
// result is then sent while the result slot is free, and a newline moves the
// line bytes into the ring one by one in S_PUSH before the walk ends.
// One item at a time: a new item is taken only once the sequencer is back in S_IDLE.
// Reset: asynchronous active low, empties line and ring, registers to defaults.
// ----------------------------------------------------------------------------
// tty_line_discipline_top
// Terminal line discipline with line editing, echo and a receive ring.
// ----------------------------------------------------------------------------
module tty_line_discipline_top import ttyld_pkg::*; #(
  parameter int BUF_SIZE = BUF_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_char
  input  logic [1:0]  s_axis_tuser,   // op
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // data, data_valid, input_ready, end_of_line
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  cfg_t       cfg_q;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_enable    <= 1'b1;
      cfg_q.canonical_mode <= 1'b1;
      cfg_q.cr_to_nl       <= 1'b1;
      cfg_q.erase_char     <= 8'd127;
      cfg_q.kill_char      <= 8'd21;
      cfg_q.eof_char       <= 8'd4;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_ECHO:  cfg_q.echo_enable    <= pwdata[0];
        REG_CANON: cfg_q.canonical_mode <= pwdata[0];
        REG_CRNL:  cfg_q.cr_to_nl       <= pwdata[0];
        REG_ERASE: cfg_q.erase_char     <= pwdata[7:0];
        REG_KILL:  cfg_q.kill_char      <= pwdata[7:0];
        REG_EOF:   cfg_q.eof_char       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_ECHO:  prdata = {31'b0, cfg_q.echo_enable};
      REG_CANON: prdata = {31'b0, cfg_q.canonical_mode};
      REG_CRNL:  prdata = {31'b0, cfg_q.cr_to_nl};
      REG_ERASE: prdata = {24'b0, cfg_q.erase_char};
      REG_KILL:  prdata = {24'b0, cfg_q.kill_char};
      REG_EOF:   prdata = {24'b0, cfg_q.eof_char};
      default:   prdata = 32'b0;
    endcase
  end

  ttyld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ttyld_dp #(
    .BUF_SIZE (BUF_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_i        (s_axis_tuser),
    .char_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== tb/sv/tty_line_discipline_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tty_line_discipline_top_test
// Drives characters, reads and flushes into the line discipline under several
// register settings and stall patterns, predicts echo and read results with a
// behavioural copy of the line editor and receive ring, and compares each
// result transfer field by field in order.
// ----------------------------------------------------------------------------
module tty_line_discipline_top_test;
  import ttyld_pkg::*;

  localparam int BUF_SIZE  = 16;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 360;

  // operation code with no function
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
  } cmd_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       data_valid;
    logic       input_ready;
    logic       end_of_line;
    logic       last;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  tty_line_discipline_top dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic       p_echo, p_canon, p_crnl;
  logic [7:0] p_erase, p_kill, p_eof;
  logic [7:0] line_buf [BUF_SIZE];
  int         line_len;
  logic [7:0] ring_buf [BUF_SIZE];
  int         ring_wr, ring_rd, ring_cnt;
  logic       line_rdy;

  cmd_item_t pending_cmds[$];
  reply_t    expected_replies[$];
  int        n_errors = 0;
  int        idle_pct = 0, stall_pct = 0;
  bit        hold_off = 1'b0;
  int        quiet_cycles = 0;

  function automatic void push_reply(logic k, logic [7:0] d, logic v, logic r, logic e);
    reply_t x;
    x = '{kind: k, data: d, data_valid: v, input_ready: r, end_of_line: e, last: 1'b0};
    expected_replies.push_back(x);
  endfunction

  function automatic void predict_echo(logic [7:0] c);
    if (!p_echo) return;
    if (c == p_erase || c == CH_BS) begin
      push_reply(KIND_ECHO, CH_BS, 1'b0, 1'b0, 1'b0);
      push_reply(KIND_ECHO, CH_SPACE, 1'b0, 1'b0, 1'b0);
      push_reply(KIND_ECHO, CH_BS, 1'b0, 1'b0, 1'b0);
    end else if ((c < CH_SPACE || c >= 8'h80) && c != CH_NL && c != CH_TAB && c != CH_CR) begin
      push_reply(KIND_ECHO, CH_CARET, 1'b0, 1'b0, 1'b0);
      push_reply(KIND_ECHO, c + CH_AT, 1'b0, 1'b0, 1'b0);
    end else begin
      push_reply(KIND_ECHO, c, 1'b0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void ring_put(logic [7:0] c);
    if (ring_cnt >= BUF_SIZE) return;
    ring_buf[ring_wr] = c;
    ring_wr = (ring_wr + 1) % BUF_SIZE;
    ring_cnt++;
  endfunction

  function automatic void predict_char(logic [7:0] c_in);
    logic [7:0] c;
    c = (p_crnl && c_in == CH_CR) ? CH_NL : c_in;
    if (!p_canon) begin
      ring_put(c);
      predict_echo(c);
    end else if (c == p_erase || c == CH_BS || c == CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        predict_echo(CH_BS);
      end
    end else if (c == p_kill) begin
      while (line_len > 0) begin
        line_len--;
        predict_echo(CH_BS);
      end
    end else if (c == p_eof) begin
      line_rdy = 1'b1;
    end else begin
      if (line_len < BUF_SIZE - 1) begin
        line_buf[line_len] = c;
        line_len++;
        predict_echo(c);
      end
      if (c == CH_NL) begin
        for (int i = 0; i < line_len; i++) ring_put(line_buf[i]);
        line_len = 0;
        line_rdy = 1'b1;
      end
    end
  endfunction

  // works out the replies of one accepted item and marks the final one
  function automatic void predict_item(cmd_item_t it);
    int n0;
    logic rdy;
    logic [7:0] b;
    n0 = expected_replies.size();
    case (it.op)
      OP_CHAR: predict_char(it.ch);
      OP_READ: begin
        rdy = line_rdy || ring_cnt > 0;
        if (p_canon) line_rdy = 1'b0;
        if (ring_cnt > 0) begin
          b = ring_buf[ring_rd];
          ring_rd = (ring_rd + 1) % BUF_SIZE;
          ring_cnt--;
          push_reply(KIND_READ, b, 1'b1, rdy, p_canon && b == CH_NL);
        end else begin
          push_reply(KIND_READ, 8'h00, 1'b0, rdy, 1'b0);
        end
      end
      OP_FLUSH: begin
        ring_wr = 0; ring_rd = 0; ring_cnt = 0; line_len = 0; line_rdy = 1'b0;
      end
      default: ;
    endcase
    if (expected_replies.size() > n0)
      expected_replies[expected_replies.size() - 1].last = 1'b1;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_item(cmd_item_t'{op: s_axis_tuser, ch: s_axis_tdata});
      void'(pending_cmds.pop_front());
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_cmds[0].op;
        s_axis_tdata  <= pending_cmds[0].ch;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and ready generator
  always @(posedge clk_i) begin
    reply_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, data: m_axis_tdata[7:0], data_valid: m_axis_tdata[8],
              input_ready: m_axis_tdata[9], end_of_line: m_axis_tdata[10],
              last: m_axis_tlast};
      if (expected_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_replies.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10) $display("result mismatch: expected %p actual %p", want, got);
        end
      end
    end
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("[tty_line_discipline_top] ERROR");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [7:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ECHO:  p_echo  = val[0];
      REG_CANON: p_canon = val[0];
      REG_CRNL:  p_crnl  = val[0];
      REG_ERASE: p_erase = val;
      REG_KILL:  p_kill  = val;
      default:   p_eof   = val;
    endcase
  endtask

  // waits until the block has drained, plus a margin for silent items
  task automatic drain();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic add(logic [1:0] op, logic [7:0] ch);
    pending_cmds.push_back(cmd_item_t'{op: op, ch: ch});
  endtask

  // mostly printable lines ended by newline, with edits, reads and noise
  task automatic add_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) add(OP_CHAR, 8'($urandom_range(8'h20, 8'h7E)));
      else if (k < 53) add(OP_CHAR, ($urandom_range(1)) ? CH_NL : CH_CR);
      else if (k < 58) add(OP_CHAR, ($urandom_range(1)) ? p_erase : CH_BS);
      else if (k < 60) add(OP_CHAR, p_kill);
      else if (k < 62) add(OP_CHAR, p_eof);
      else if (k < 70) add(OP_CHAR, 8'($urandom));
      else if (k < 94) add(OP_READ, 8'($urandom));
      else if (k < 97) add(OP_FLUSH, 8'($urandom));
      else add(OP_SPARE, 8'($urandom));
    end
  endtask

  initial begin
    p_echo = 1; p_canon = 1; p_crnl = 1; p_erase = 8'd127; p_kill = 8'd21; p_eof = 8'd4;
    line_len = 0; ring_wr = 0; ring_rd = 0; ring_cnt = 0; line_rdy = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: edits, echo forms, overflow of line, reads, flush, unused op
    add(OP_READ, 8'h00);
    add(OP_CHAR, CH_DEL);
    add(OP_CHAR, 8'h00); add(OP_CHAR, 8'hFF); add(OP_CHAR, CH_TAB); add(OP_CHAR, 8'h80);
    add(OP_CHAR, CH_BS); add(OP_CHAR, 8'h41); add(OP_CHAR, 8'd21);
    for (int i = 0; i < 17; i++) add(OP_CHAR, 8'h61 + 8'(i));
    add(OP_CHAR, CH_CR);
    add(OP_CHAR, 8'd4);
    repeat (3) add(OP_READ, 8'h00);
    add(OP_SPARE, 8'hAA);
    add(OP_FLUSH, 8'h55);
    add(OP_READ, 8'h00);
    drain();

    // receiver holds off while the sender keeps offering
    add_random(40);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
    drain();

    // phases under several settings and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin reg_write(REG_ECHO, 0); reg_write(REG_CANON, 0); reg_write(REG_CRNL, 0);
                 reg_write(REG_ERASE, 8'h00); reg_write(REG_KILL, 8'hFF);
                 reg_write(REG_EOF, 8'hFF); idle_pct = 0; stall_pct = 0; end
        1: begin reg_write(REG_ECHO, 1); reg_write(REG_CANON, 1); reg_write(REG_CRNL, 0);
                 reg_write(REG_ERASE, 8'hFF); reg_write(REG_KILL, 8'h00);
                 reg_write(REG_EOF, 8'h00); idle_pct = 67; stall_pct = 0; end
        2: begin reg_write(REG_ECHO, 1); reg_write(REG_CANON, 0); reg_write(REG_CRNL, 1);
                 reg_write(REG_ERASE, 8'h61); reg_write(REG_KILL, 8'h61);
                 reg_write(REG_EOF, 8'h62); idle_pct = 0; stall_pct = 67; end
        default: begin reg_write(REG_CANON, 1); reg_write(REG_ERASE, 8'd127);
                 reg_write(REG_KILL, 8'd21); reg_write(REG_EOF, 8'd4);
                 idle_pct = 17; stall_pct = 17; end
      endcase
      add_random(N_RANDOM / 4);
      drain();
    end

    if (n_errors == 0)
      $display("[tty_line_discipline_top] OK");
    else
      $display("[tty_line_discipline_top] ERROR");
    $finish;
  end
endmodule
